// ===== hdl/lss_pkg.sv =====
package lss_pkg;

    typedef logic [1:0]         req_t;
    typedef logic [1:0]         status_t;
    typedef logic signed [31:0] data_t;
    typedef logic [5:0]         pos_t;
    typedef logic [6:0]         fill_t;

    localparam req_t REQ_PUSH   = 2'd0;
    localparam req_t REQ_POP    = 2'd1;
    localparam req_t REQ_LIST   = 2'd2;
    localparam req_t REQ_SEARCH = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EMPTY     = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    // Per-cycle command shared by every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic rotate;
    } cell_ctrl_t;

endpackage

// ===== hdl/lss_if.sv =====
interface lss_req_if;
    logic            valid;
    logic            ready;
    lss_pkg::req_t   req_type;
    lss_pkg::data_t  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface lss_rsp_if;
    logic              valid;
    logic              ready;
    lss_pkg::status_t  status;
    lss_pkg::data_t    value_out;
    lss_pkg::pos_t     position;
    lss_pkg::fill_t    fill_level;
    logic              last;

    modport source (output valid, output status, output value_out, output position,
                    output fill_level, output last, input ready);
    modport sink   (input valid, input status, input value_out, input position,
                    input fill_level, input last, output ready);
endinterface

// ===== hdl/lss_cell.sv =====
module lss_cell
(
    input  logic                clk,
    input  lss_pkg::cell_ctrl_t ctrl,
    input  logic                wrap,
    input  lss_pkg::data_t      above,
    input  lss_pkg::data_t      below,
    input  lss_pkg::data_t      top,
    output lss_pkg::data_t      q
);

    lss_pkg::data_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            data_reg <= above;
        end
        else if (ctrl.pop)
        begin
            data_reg <= below;
        end
        else if (ctrl.rotate)
        begin
            // the deepest held entry takes the top entry around the ring
            data_reg <= wrap ? top : below;
        end
    end

    assign q = data_reg;

endmodule

// ===== hdl/lifo_stack_with_search.sv =====
// LIFO stack of signed 32-bit values, held in a chain of cells with the top at cell 0.
// Channel req (sink): req_type selects push, pop, list or search; value is the
// operand. Channel rsp (source): status, value_out, position, fill_level and last
// per result beat; the final beat of every request carries last.
// Push and pop answer in the cycle after acceptance through the output register.
// List rotates the chain one cell per cycle while the output slot is free and emits
// one beat per held entry, top first. Search rotates the chain once around all held
// entries, comparing cell 0 against the key, and answers when the rotation ends.
// The rotation brings the stack back to its original order. Requests are taken one
// at a time: req.ready is high only while no list or search is running and the
// output register is free or being drained. A list or search holds the block for
// one rotation step per held entry. Reset empties the stack at once; cells keep
// data. A stalled rsp holds its beat and freezes a running list.
module lifo_stack_with_search
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    lss_req_if.sink  req,
    lss_rsp_if.source rsp
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LIST   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    idx_reg, idx_next;
    lss_pkg::data_t   key_reg, key_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    hit_reg, hit_next;

    logic             out_valid_reg, out_valid_next;
    lss_pkg::status_t out_status_reg, out_status_next;
    lss_pkg::data_t   out_value_reg, out_value_next;
    lss_pkg::pos_t    out_pos_reg, out_pos_next;
    lss_pkg::fill_t   out_fill_reg, out_fill_next;
    logic             out_last_reg, out_last_next;

    lss_pkg::cell_ctrl_t ctrl;
    lss_pkg::data_t      cell_q [STACK_DEPTH];

    logic slot_free, accept, full, empty, idx_last, hit;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == CW'(STACK_DEPTH);
    assign empty     = count_reg == '0;
    assign idx_last  = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign hit       = cell_q[0] == key_reg;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            lss_pkg::data_t above, below;
            logic           wrap;

            if (gi == 0)
            begin : g_first
                assign above = req.value;
            end
            else
            begin : g_mid
                assign above = cell_q[gi-1];
            end

            if (gi == STACK_DEPTH - 1)
            begin : g_end
                assign below = '0;
            end
            else
            begin : g_inner
                assign below = cell_q[gi+1];
            end

            assign wrap = count_reg == CW'(gi + 1);

            lss_cell u_cell
            (
                .clk   (clk),
                .ctrl  (ctrl),
                .wrap  (wrap),
                .above (above),
                .below (below),
                .top   (cell_q[0]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        ctrl            = '0;
        out_valid_next  = slot_free ? 1'b0 : out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        out_fill_next   = out_fill_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_value_next = '0;
                    out_pos_next   = '0;
                    out_fill_next  = lss_pkg::fill_t'(count_reg);
                    out_last_next  = 1'b1;
                    case (req.req_type)
                        lss_pkg::REQ_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_status_next = lss_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.push       = 1'b1;
                                count_next      = count_reg + CW'(1);
                                out_status_next = lss_pkg::ST_OK;
                                out_fill_next   = lss_pkg::fill_t'(count_reg + CW'(1));
                            end
                        end
                        lss_pkg::REQ_POP:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                out_status_next = lss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.pop        = 1'b1;
                                count_next      = count_reg - CW'(1);
                                out_status_next = lss_pkg::ST_OK;
                                out_value_next  = cell_q[0];
                                out_fill_next   = lss_pkg::fill_t'(count_reg - CW'(1));
                            end
                        end
                        lss_pkg::REQ_LIST:
                        begin
                            if (empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = lss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LIST;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = lss_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                                idx_next   = '0;
                                found_next = 1'b0;
                                key_next   = req.value;
                            end
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                // advance one entry per free output slot
                if (slot_free)
                begin
                    ctrl.rotate     = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = lss_pkg::ST_OK;
                    out_value_next  = cell_q[0];
                    out_pos_next    = lss_pkg::pos_t'(idx_reg);
                    out_fill_next   = lss_pkg::fill_t'(count_reg);
                    out_last_next   = idx_last;
                    idx_next        = idx_reg + IW'(1);
                    if (idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SEARCH:
            begin
                // keep rotating after a hit so the order is restored
                ctrl.rotate = 1'b1;
                idx_next    = idx_reg + IW'(1);
                if (!found_reg && hit)
                begin
                    found_next = 1'b1;
                    hit_next   = idx_reg;
                end
                if (idx_last)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_fill_next  = lss_pkg::fill_t'(count_reg);
                    out_last_next  = 1'b1;
                    if (found_reg)
                    begin
                        out_status_next = lss_pkg::ST_OK;
                        out_pos_next    = lss_pkg::pos_t'(hit_reg);
                    end
                    else if (hit)
                    begin
                        out_status_next = lss_pkg::ST_OK;
                        out_pos_next    = lss_pkg::pos_t'(idx_reg);
                    end
                    else
                    begin
                        out_status_next = lss_pkg::ST_NOT_FOUND;
                        out_pos_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        found_reg      <= found_next;
        hit_reg        <= hit_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_pos_reg    <= out_pos_next;
        out_fill_reg   <= out_fill_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.value_out  = out_value_reg;
    assign rsp.position   = out_pos_reg;
    assign rsp.fill_level = out_fill_reg;
    assign rsp.last       = out_last_reg;

endmodule

// ===== hdl/lss_checker.sv =====
module lss_checker
#(
    parameter int DEPTH = 32
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input lss_pkg::status_t status,
    input lss_pkg::data_t   value_out,
    input lss_pkg::pos_t    position,
    input lss_pkg::fill_t   fill_level,
    input logic             last
);

    // hold a stalled beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(value_out)
            && $stable(position) && $stable(fill_level) && $stable(last))
        else $error("stalled response beat changed");

    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == lss_pkg::ST_FULL |-> fill_level == lss_pkg::fill_t'(DEPTH))
        else $error("full status without a full stack");

    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == lss_pkg::ST_EMPTY |-> fill_level == '0 && last)
        else $error("empty status with entries held");

    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && position != '0 |-> status == lss_pkg::ST_OK
            && fill_level > lss_pkg::fill_t'(position))
        else $error("position outside the held entries");

    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && value_out != '0 |-> status == lss_pkg::ST_OK)
        else $error("nonzero value on a failed request");

endmodule

bind lifo_stack_with_search lss_checker #(.DEPTH(STACK_DEPTH)) u_lss_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .value_out  (rsp.value_out),
    .position   (rsp.position),
    .fill_level (rsp.fill_level),
    .last       (rsp.last)
);
